// ===== rtl/core/vts_pkg.sv =====
// Package for the volume trilinear sampler: item structs, register indexes,
// controller/datapath command and status types, and default dimensions.
// No dependencies.
`default_nettype none

package vts_pkg;

  localparam int unsigned DEF_DIM_X         = 64;
  localparam int unsigned DEF_DIM_Y         = 64;
  localparam int unsigned DEF_DIM_Z         = 64;
  localparam int unsigned DEF_VOXEL_BITS    = 16;
  localparam int unsigned DEF_POS_FRAC_BITS = 8;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned INV_W   = 24;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned WIDX_W  = 6;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned WFRAC   = 10;
  localparam int unsigned WGT_W   = WFRAC + 1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;

  localparam logic [CIDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CIDX_W-1:0] REG_INV_SP_X = 3'd3;
  localparam logic [CIDX_W-1:0] REG_INV_SP_Y = 3'd4;
  localparam logic [CIDX_W-1:0] REG_INV_SP_Z = 3'd5;
  localparam logic [CIDX_W-1:0] REG_MODE     = 3'd6;

  localparam logic [INV_W-1:0]  INV_SP_RESET = 24'd65536;

  typedef struct packed {
    logic                    cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [WIDX_W-1:0]       wr_x;
    logic [WIDX_W-1:0]       wr_y;
    logic [WIDX_W-1:0]       wr_z;
    logic signed [VAL_W-1:0] wr_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic                    sample_valid;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       write;
    logic       mul_en;
    logic [1:0] axis;
    logic       check;
    logic       issue;
    logic [2:0] nb;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sample_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/vts_ctrl.sv =====
// Controller state machine of the volume trilinear sampler.
// Sequences coordinate mapping, neighbor reads and result hand-off; uses vts_pkg.
`default_nettype none

module vts_ctrl
  import vts_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_cmd_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_EVAL,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  localparam logic [2:0] LAST_AXIS  = 3'd2;
  localparam logic [2:0] LAST_NB    = 3'd7;
  localparam logic [2:0] LAST_DRAIN = 3'd2;

  state_e     state_q;
  logic [2:0] cnt_q;
  logic       out_valid_q;
  logic       accept;
  logic       out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept && (in_cmd_i == CMD_SAMPLE);
    cmd_o.write    = accept && (in_cmd_i == CMD_WRITE);
    cmd_o.mul_en   = (state_q == ST_MUL);
    cmd_o.axis     = cnt_q[1:0];
    cmd_o.check    = (state_q == ST_CHECK);
    cmd_o.issue    = (state_q == ST_ISSUE);
    cmd_o.nb       = cnt_q;
    cmd_o.out_load = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept && (in_cmd_i == CMD_SAMPLE)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == LAST_AXIS) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          cnt_q   <= '0;
          state_q <= stat_i.sample_ok ? ST_ISSUE : ST_DONE;
        end
        ST_ISSUE: begin
          if (cnt_q == LAST_NB) begin
            cnt_q   <= '0;
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_DRAIN: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == LAST_DRAIN) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vts_datapath.sv =====
// Datapath of the volume trilinear sampler: configuration registers, voxel
// memory, shared coordinate multiplier, weight pipeline and accumulator.
// Uses vts_pkg.
`default_nettype none

module vts_datapath
  import vts_pkg::*;
#(
  parameter int unsigned DIM_X         = DEF_DIM_X,
  parameter int unsigned DIM_Y         = DEF_DIM_Y,
  parameter int unsigned DIM_Z         = DEF_DIM_Z,
  parameter int unsigned VOXEL_BITS    = DEF_VOXEL_BITS,
  parameter int unsigned POS_FRAC_BITS = DEF_POS_FRAC_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CIDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  input  wire in_item_t            in_i,
  input  wire dp_cmd_t             cmd_i,
  output dp_stat_t                 stat_o,
  output out_item_t                out_o
);

  localparam int unsigned CF     = POS_FRAC_BITS + 16;
  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned U_W    = DIFF_W + INV_W + 1;
  localparam int unsigned B_W    = U_W - CF;
  localparam int unsigned DMAX   = (DIM_X > DIM_Y) ? ((DIM_X > DIM_Z) ? DIM_X : DIM_Z)
                                                   : ((DIM_Y > DIM_Z) ? DIM_Y : DIM_Z);
  localparam int unsigned IW     = $clog2(DMAX) + 2;
  localparam int unsigned XW     = $clog2(DIM_X);
  localparam int unsigned YW     = $clog2(DIM_Y);
  localparam int unsigned ZW     = $clog2(DIM_Z);
  localparam int unsigned NVOX   = DIM_X * DIM_Y * DIM_Z;
  localparam int unsigned AW     = $clog2(NVOX);
  localparam int unsigned W2_W   = 2 * WGT_W;
  localparam int unsigned W3_W   = 3 * WFRAC + 1;
  localparam int unsigned P_W    = W3_W + 1 + VOXEL_BITS;
  localparam int unsigned ACC_W  = 3 * WFRAC + VOXEL_BITS + 2;
  localparam int unsigned SH     = 3 * WFRAC;

  localparam logic signed [U_W-1:0]   HALF   = U_W'(1) <<< (CF - 1);
  localparam logic [WGT_W-1:0]        WONE   = WGT_W'(1) << WFRAC;
  localparam logic signed [ACC_W-1:0] RND    = (ACC_W'(1) <<< SH) - ACC_W'(1);

  logic signed [POS_W-1:0] org_q [3];
  logic [INV_W-1:0]        inv_q [3];
  logic [MODE_W-1:0]       mode_q;

  logic signed [POS_W-1:0]  pos_q [3];
  logic signed [U_W-1:0]    u_q   [3];
  logic signed [IW-1:0]     base_q[3];
  logic [WFRAC-1:0]         k_q   [3];
  logic                     ok_q;

  logic [VOXEL_BITS-1:0]    mem [NVOX];
  logic [VOXEL_BITS-1:0]    rd_q;
  logic                     in_q, v1_q, v2_q, v3_q;
  logic [W2_W-1:0]          wxy_q;
  logic [WGT_W-1:0]         wz_q;
  logic [W3_W-1:0]          w3_q;
  logic signed [VOXEL_BITS-1:0] vox_q;
  logic signed [P_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  out_item_t                out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        inv_q[i] <= INV_SP_RESET;
      end
      mode_q <= MODE_LINEAR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: org_q[0] <= cfg_wdata_i;
        REG_ORIGIN_Y: org_q[1] <= cfg_wdata_i;
        REG_ORIGIN_Z: org_q[2] <= cfg_wdata_i;
        REG_INV_SP_X: inv_q[0] <= cfg_wdata_i;
        REG_INV_SP_Y: inv_q[1] <= cfg_wdata_i;
        REG_INV_SP_Z: inv_q[2] <= cfg_wdata_i;
        REG_MODE:     mode_q   <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Coordinate mapping: one axis per cycle through a shared multiplier.
  logic signed [DIFF_W-1:0] diff;
  logic signed [U_W-1:0]    u_d;
  always_comb begin
    diff = DIFF_W'(pos_q[cmd_i.axis]) - DIFF_W'(org_q[cmd_i.axis]);
    u_d  = U_W'(diff * $signed({1'b0, inv_q[cmd_i.axis]}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q[0] <= in_i.pos_x;
      pos_q[1] <= in_i.pos_y;
      pos_q[2] <= in_i.pos_z;
    end
    if (cmd_i.mul_en) begin
      u_q[cmd_i.axis] <= u_d;
    end
  end

  // Base index, fraction and range check.
  logic                  lin;
  logic signed [U_W-1:0] v   [3];
  logic signed [B_W-1:0] b   [3];
  logic                  ax_ok [3];
  logic                  ok_d;
  int unsigned           dims [3];
  always_comb begin
    dims[0] = DIM_X;
    dims[1] = DIM_Y;
    dims[2] = DIM_Z;
    lin     = (mode_q == MODE_LINEAR);
    ok_d    = (mode_q == MODE_LINEAR) || (mode_q == MODE_NEAREST);
    for (int i = 0; i < 3; i++) begin
      v[i]     = lin ? (u_q[i] - HALF) : u_q[i];
      b[i]     = v[i][U_W-1:CF];
      ax_ok[i] = (b[i] >= (lin ? -$signed(B_W'(1)) : $signed(B_W'(0)))) &&
                 (b[i] < $signed(B_W'(dims[i])));
      ok_d     = ok_d && ax_ok[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      ok_q <= ok_d;
      for (int i = 0; i < 3; i++) begin
        base_q[i] <= IW'(b[i]);
        k_q[i]    <= lin ? v[i][CF-1 -: WFRAC] : '0;
      end
    end
  end

  assign stat_o.sample_ok = ok_q;

  // Neighbor address, inside test and weights.
  logic signed [IW:0]  c   [3];
  logic                ins;
  logic [WGT_W-1:0]    w   [3];
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                wr_in;
  always_comb begin
    ins = lin || (cmd_i.nb == 3'd0);
    for (int i = 0; i < 3; i++) begin
      c[i] = (IW + 1)'(base_q[i]) + (IW + 1)'(cmd_i.nb[i]);
      ins  = ins && (c[i] >= 0) && (c[i] < $signed((IW + 1)'(dims[i])));
      w[i] = cmd_i.nb[i] ? {1'b0, k_q[i]} : (WONE - {1'b0, k_q[i]});
    end
    rd_addr = (AW'(c[2][ZW-1:0]) * AW'(DIM_Y) + AW'(c[1][YW-1:0])) * AW'(DIM_X)
              + AW'(c[0][XW-1:0]);
    wr_addr = (AW'(in_i.wr_z) * AW'(DIM_Y) + AW'(in_i.wr_y)) * AW'(DIM_X)
              + AW'(in_i.wr_x);
    wr_in   = (32'(in_i.wr_x) < DIM_X) && (32'(in_i.wr_y) < DIM_Y) &&
              (32'(in_i.wr_z) < DIM_Z);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_in) begin
      mem[wr_addr] <= VOXEL_BITS'(in_i.wr_value);
    end
    rd_q <= mem[rd_addr];
  end

  // Weight and product pipeline.
  always_ff @(posedge clk_i) begin
    in_q   <= ins;
    wxy_q  <= W2_W'(w[0] * w[1]);
    wz_q   <= w[2];
    w3_q   <= W3_W'(wxy_q * wz_q);
    vox_q  <= in_q ? $signed(rd_q) : '0;
    prod_q <= P_W'($signed({1'b0, w3_q}) * vox_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Divide by the weight scale, truncating toward zero.
  logic signed [ACC_W-1:0]    adj;
  logic signed [ACC_W-SH-1:0] quo;
  always_comb begin
    adj = acc_q + (acc_q[ACC_W-1] ? RND : '0);
    quo = adj[ACC_W-1:SH];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.sample_valid <= ok_q;
      out_q.sample_value <= ok_q ? VAL_W'(quo) : '0;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/volume_trilinear_sampler.sv =====
// Volume trilinear sampler top level: controller and datapath.
// Uses vts_pkg, vts_ctrl and vts_datapath.
//
// The block stores a voxel volume filled by write items (cmd 0) and answers
// sample items (cmd 1) with one nearest or trilinear result each. A write
// gives no result. After its transfer a sample keeps the input ready low
// through its steps: the three axes in turn on the shared coordinate
// multiplier, range checking, reading the neighbors one by one from the
// voxel memory, draining the weight pipeline, and handing the result to the
// output register; an out-of-range sample or an unknown mode skips the reads
// and the drain. The hand-off step repeats for as long as the previous
// result has not been taken. The volume needs no clearing after reset, and a
// voxel never written reads as an arbitrary value.
`default_nettype none

module volume_trilinear_sampler
  import vts_pkg::*;
#(
  parameter int unsigned DIM_X         = DEF_DIM_X,
  parameter int unsigned DIM_Y         = DEF_DIM_Y,
  parameter int unsigned DIM_Z         = DEF_DIM_Z,
  parameter int unsigned VOXEL_BITS    = DEF_VOXEL_BITS,
  parameter int unsigned POS_FRAC_BITS = DEF_POS_FRAC_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CIDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  vts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  vts_datapath #(
    .DIM_X         (DIM_X),
    .DIM_Y         (DIM_Y),
    .DIM_Z         (DIM_Z),
    .VOXEL_BITS    (VOXEL_BITS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_o       (out_o)
  );

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_i.cmd == CMD_SAMPLE)) |=> !in_ready_o)
    else $error("Ready stayed high after a sample transfer.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o)))
    else $error("Stalled result changed or dropped.");

  a_issue_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.issue |-> (!dp_cmd.load && !dp_cmd.write && !dp_cmd.out_load))
    else $error("Neighbor read overlaps another datapath command.");

endmodule

`default_nettype wire

// ===== sim/tb_volume_trilinear_sampler.sv =====
// Testbench for volume_trilinear_sampler: directed and random write/sample
// transfers, checked against a behavioral predictor of nearest and trilinear
// sampling. Depends on vts_pkg and the RTL of the sampler.
`default_nettype none

module tb_volume_trilinear_sampler;
  import vts_pkg::*;

  localparam int NX = DEF_DIM_X;
  localparam int NY = DEF_DIM_Y;
  localparam int NZ = DEF_DIM_Z;
  localparam int NVOX = NX * NY * NZ;
  localparam int COORD_FRAC = DEF_POS_FRAC_BITS + 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CIDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_o;

  volume_trilinear_sampler dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_i, .out_valid_o, .out_ready_i, .out_o
  );

  always #5 clk_i = ~clk_i;

  logic signed [POS_W-1:0] vol_origin [3];
  logic [INV_W-1:0] vol_inv [3];
  logic [MODE_W-1:0] vol_mode;
  logic signed [VAL_W-1:0] voxel_mem [NVOX];
  bit voxel_set [NVOX];
  int touched_q[$];
  out_item_t sample_q[$];
  int mismatches = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int cycles = 0;
  int sent = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sample_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", out_o);
      end else begin
        out_item_t want;
        want = sample_q.pop_front();
        if (out_o.sample_value !== want.sample_value ||
            out_o.sample_valid !== want.sample_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Sample mismatch: expected value %0d valid %0d, got value %0d valid %0d",
                     want.sample_value, want.sample_valid, out_o.sample_value,
                     out_o.sample_valid);
        end
      end
    end
  end

  function automatic longint to_voxel_coord(logic signed [POS_W-1:0] p,
                                            logic signed [POS_W-1:0] o,
                                            logic [INV_W-1:0] s);
    longint d;
    d = longint'(p) - longint'(o);
    return d * longint'(s);
  endfunction

  // Fills touched_q with every in-volume voxel the sample reads.
  function automatic out_item_t eval_sample(in_item_t it);
    out_item_t r;
    longint u [3];
    longint b [3];
    longint k [3];
    longint sum;
    longint w;
    longint t;
    int x, y, z, idx;
    r = '0;
    sum = 0;
    touched_q.delete();
    u[0] = to_voxel_coord(it.pos_x, vol_origin[0], vol_inv[0]);
    u[1] = to_voxel_coord(it.pos_y, vol_origin[1], vol_inv[1]);
    u[2] = to_voxel_coord(it.pos_z, vol_origin[2], vol_inv[2]);
    if (vol_mode == MODE_NEAREST) begin
      if (u[0] >= 0 && u[1] >= 0 && u[2] >= 0) begin
        for (int i = 0; i < 3; i++) b[i] = u[i] >>> COORD_FRAC;
        if (b[0] < NX && b[1] < NY && b[2] < NZ) begin
          idx = int'((b[2] * NY + b[1]) * NX + b[0]);
          touched_q.push_back(idx);
          r.sample_value = voxel_mem[idx];
          r.sample_valid = 1'b1;
        end
      end
    end else if (vol_mode == MODE_LINEAR) begin
      for (int i = 0; i < 3; i++) begin
        t = u[i] - (64'sd1 <<< (COORD_FRAC - 1));
        b[i] = t >>> COORD_FRAC;
        k[i] = (t >>> (COORD_FRAC - WFRAC)) & ((64'sd1 <<< WFRAC) - 1);
      end
      if (b[0] >= -1 && b[1] >= -1 && b[2] >= -1 &&
          b[0] < NX && b[1] < NY && b[2] < NZ) begin
        for (int c = 0; c < 2; c++)
          for (int bb = 0; bb < 2; bb++)
            for (int a = 0; a < 2; a++) begin
              x = int'(b[0]) + a;
              y = int'(b[1]) + bb;
              z = int'(b[2]) + c;
              if (x >= 0 && y >= 0 && z >= 0 && x < NX && y < NY && z < NZ) begin
                idx = (z * NY + y) * NX + x;
                touched_q.push_back(idx);
                w = (a ? k[0] : 1024 - k[0]) * (bb ? k[1] : 1024 - k[1]) *
                    (c ? k[2] : 1024 - k[2]);
                sum += w * longint'(voxel_mem[idx]);
              end
            end
        t = sum / (64'sd1 <<< (3 * WFRAC));
        r.sample_value = t[VAL_W-1:0];
        r.sample_valid = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_transfer(in_item_t it, bit typed, out_item_t res);
    int idx;
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (it.cmd == CMD_WRITE) begin
      idx = (int'(it.wr_z) * NY + int'(it.wr_y)) * NX + int'(it.wr_x);
      voxel_mem[idx] = it.wr_value;
      voxel_set[idx] = 1'b1;
    end else begin
      out_item_t r;
      r = eval_sample(it);
      sample_q.push_back(typed ? res : r);
    end
  endtask

  function automatic logic signed [VAL_W-1:0] rand_voxel_value();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Writes any unwritten voxel the sample would read, then sends the sample.
  task automatic send_sample(in_item_t it, bit typed, out_item_t res);
    int need[$];
    in_item_t wr;
    out_item_t dummy;
    dummy = eval_sample(it);
    need = touched_q;
    foreach (need[i]) begin
      if (!voxel_set[need[i]]) begin
        wr = '0;
        wr.cmd = CMD_WRITE;
        wr.wr_x = WIDX_W'(need[i] % NX);
        wr.wr_y = WIDX_W'((need[i] / NX) % NY);
        wr.wr_z = WIDX_W'(need[i] / (NX * NY));
        wr.wr_value = rand_voxel_value();
        wr.pos_x = POS_W'($urandom);
        send_transfer(wr, 1'b0, '0);
      end
    end
    send_transfer(it, typed, res);
  endtask

  task automatic write_config(logic signed [POS_W-1:0] ox, logic signed [POS_W-1:0] oy,
                              logic signed [POS_W-1:0] oz, logic [INV_W-1:0] sx,
                              logic [INV_W-1:0] sy, logic [INV_W-1:0] sz,
                              logic [MODE_W-1:0] m);
    logic [CIDX_W-1:0] regs [7];
    logic [CFG_W-1:0] vals [7];
    regs = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z, REG_INV_SP_X, REG_INV_SP_Y,
             REG_INV_SP_Z, REG_MODE};
    vals = '{ox, oy, oz, sx, sy, sz, CFG_W'(m)};
    in_valid_i <= 1'b0;
    wait (sample_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 7; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= regs[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    vol_origin = '{ox, oy, oz};
    vol_inv = '{sx, sy, sz};
    vol_mode = m;
  endtask

  // Position that lands near the volume in voxel space, clamped to the field.
  function automatic logic signed [POS_W-1:0] near_pos(int axis);
    longint u8;
    longint p;
    if ($urandom_range(99) < 12 || vol_inv[axis] == 0) return POS_W'($urandom);
    u8 = longint'($urandom_range(17408)) - 768;
    p = longint'(vol_origin[axis]) + (u8 * 65536) / longint'(vol_inv[axis]);
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    return p[POS_W-1:0];
  endfunction

  // Sends about count transfers, the writes that fill a sample's voxels included.
  task automatic random_phase(int count);
    in_item_t it;
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      it.cmd = CMD_SAMPLE;
      it.pos_x = near_pos(0);
      it.pos_y = near_pos(1);
      it.pos_z = near_pos(2);
      it.wr_x = WIDX_W'($urandom);
      it.wr_y = WIDX_W'($urandom);
      it.wr_z = WIDX_W'($urandom);
      it.wr_value = rand_voxel_value();
      if ($urandom_range(99) < 15) begin
        it.cmd = CMD_WRITE;
        send_transfer(it, 1'b0, '0);
      end else begin
        send_sample(it, 1'b0, '0);
      end
    end
  endtask

  function automatic stim_row_t row(logic c, int px, int py, int pz, int wx, int wy, int wz,
                                    int wv, bit typed, int ev, bit eok);
    stim_row_t r;
    r.it = '{cmd: c, pos_x: POS_W'(px), pos_y: POS_W'(py), pos_z: POS_W'(pz),
             wr_x: WIDX_W'(wx), wr_y: WIDX_W'(wy), wr_z: WIDX_W'(wz),
             wr_value: VAL_W'(wv)};
    r.typed = typed;
    r.res = '{sample_value: VAL_W'(ev), sample_valid: eok};
    return r;
  endfunction

  stim_row_t directed [$];

  initial begin
    vol_origin = '{0, 0, 0};
    vol_inv = '{INV_SP_RESET, INV_SP_RESET, INV_SP_RESET};
    vol_mode = MODE_LINEAR;
    foreach (voxel_set[i]) voxel_set[i] = 1'b0;
    foreach (voxel_mem[i]) voxel_mem[i] = '0;

    directed.push_back(row(CMD_WRITE, 0, 0, 0, 0, 0, 0, 100, 0, 0, 0));
    directed.push_back(row(CMD_WRITE, 0, 0, 0, 1, 0, 0, 32767, 0, 0, 0));
    directed.push_back(row(CMD_WRITE, 0, 0, 0, 0, 1, 0, -32768, 0, 0, 0));
    directed.push_back(row(CMD_WRITE, 0, 0, 0, 1, 1, 0, 32767, 0, 0, 0));
    directed.push_back(row(CMD_WRITE, 0, 0, 0, 0, 0, 1, -1, 0, 0, 0));
    directed.push_back(row(CMD_WRITE, 0, 0, 0, 1, 0, 1, 32767, 0, 0, 0));
    directed.push_back(row(CMD_WRITE, 0, 0, 0, 0, 1, 1, 32767, 0, 0, 0));
    directed.push_back(row(CMD_WRITE, 0, 0, 0, 1, 1, 1, -32768, 0, 0, 0));
    directed.push_back(row(CMD_WRITE, -1, -1, -1, 63, 63, 63, -32768, 0, 0, 0));
    directed.push_back(row(CMD_SAMPLE, 128, 128, 128, 0, 0, 0, 0, 1, 100, 1));
    directed.push_back(row(CMD_SAMPLE, -128, -128, -128, 0, 0, 0, 0, 1, 0, 1));
    directed.push_back(row(CMD_SAMPLE, 256, 256, 256, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(CMD_SAMPLE, 200, 300, 140, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(CMD_SAMPLE, 16256, 16256, 16256, 63, 63, 63, 0, 1, -32768, 1));
    directed.push_back(row(CMD_SAMPLE, 16512, 16512, 16512, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(row(CMD_SAMPLE, 128, 128, 16512, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(row(CMD_SAMPLE, -384, 128, 128, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(row(CMD_SAMPLE, -8388608, -8388608, -8388608, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(row(CMD_SAMPLE, 8388607, 8388607, 8388607, 0, 0, 0, 0, 1, 0, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle = 20;
    rx_idle = 54;
    foreach (directed[i]) begin
      if (directed[i].it.cmd == CMD_WRITE) send_transfer(directed[i].it, 1'b0, '0);
      else send_sample(directed[i].it, directed[i].typed, directed[i].res);
    end

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_config(0, 0, 0, 65536, 65536, 65536, MODE_NEAREST);
        1: write_config(-24'sd8388608, 24'sd8388607, 1000, 24'hffffff, 0, 32768, MODE_LINEAR);
        2: write_config(POS_W'(int'($urandom_range(4000)) - 2000), -300, 777,
                        INV_W'($urandom_range(262144, 16384)),
                        INV_W'($urandom_range(262144, 16384)),
                        INV_W'($urandom_range(262144, 16384)), MODE_LINEAR);
        3: write_config(5, 6, 7, 65536, 65536, 65536, 2'd2);
        4: write_config(-5, -6, -7, 70000, 40000, 1, 2'd3);
        5: write_config(POS_W'(int'($urandom_range(4000)) - 2000), 1280, -640,
                        INV_W'($urandom_range(200000, 20000)), 131072, 45000,
                        MODE_NEAREST);
        default: write_config(-512, 256, 0, 65536, 98304, 50000, MODE_LINEAR);
      endcase
      if (ph < 2) begin
        tx_idle = 20;
        rx_idle = 54;
      end else if (ph < 5) begin
        tx_idle = 54;
        rx_idle = 20;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      random_phase((ph == 3 || ph == 4) ? 50 : 180);
    end

    in_valid_i <= 1'b0;
    wait (sample_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
